### hw/rtl/msap_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the angle-to-width function of the servo pulse generator.
// No dependencies.
package msap_pkg;

    localparam int PINS_W    = 8;
    localparam int CHAN_W    = 8;
    localparam int ANGLE_W   = 8;
    localparam int BASE_W    = 8;
    localparam int GAP_W     = 12;
    localparam int COUNT_W   = 12;
    localparam int PWIDTH_W  = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 12;

    // Slots in the width phase of each frame.
    localparam logic [COUNT_W-1:0] WIDTH_SLOTS = 12'd200;

    // Reset values of the configuration registers.
    localparam logic [BASE_W-1:0] BASE_HIGH_RESET = 8'd50;
    localparam logic [GAP_W-1:0]  GAP_RESET       = 12'd1749;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_BASE_HIGH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAP       = 2'd1;

    // Command codes.
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_SET  = 1'b1;

    // Status codes.
    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_BAD_CHAN = 1'b1;

    // Angle limits for an enabled channel.
    localparam logic signed [ANGLE_W-1:0] ANGLE_MAX = 8'sd90;
    localparam logic signed [ANGLE_W-1:0] ANGLE_MIN = -8'sd90;

    typedef enum logic [1:0] {
        PH_BASE  = 2'd0,
        PH_WIDTH = 2'd1,
        PH_GAP   = 2'd2
    } phase_t;

    typedef struct packed {
        phase_t             phase;
        logic [COUNT_W-1:0] count;
    } frame_t;

    // floor((8*ang + 900) / 9) for ang in -90..90. The numerator is 180..1620;
    // multiply by ceil(2^16/9) and drop 16 bits, exact over that range.
    localparam logic [12:0] RECIP_9 = 13'd7282;

    function automatic logic [PWIDTH_W-1:0] angle_width(input logic signed [ANGLE_W-1:0] ang);
        logic signed [11:0] num_s;
        logic [10:0]        num;
        logic [23:0]        prod;
        num_s = ({{4{ang[ANGLE_W-1]}}, ang} <<< 3) + 12'sd900;
        num   = num_s[10:0];
        prod  = 24'(num) * 24'(RECIP_9);
        return prod[23:16];
    endfunction

endpackage

### hw/rtl/msap_in_if.sv
`timescale 1ns / 1ps
// Command channel of the servo pulse generator: valid/ready plus one command item.
// Depends on msap_pkg.
interface msap_in_if;
    logic                          valid;
    logic                          ready;
    logic                          cmd;
    logic [msap_pkg::CHAN_W-1:0]   channel;
    logic signed [msap_pkg::ANGLE_W-1:0] angle;

    modport source (output valid, output cmd, output channel, output angle, input ready);
    modport sink   (input valid, input cmd, input channel, input angle, output ready);
endinterface

### hw/rtl/msap_out_if.sv
`timescale 1ns / 1ps
// Result channel of the servo pulse generator: valid/ready plus one result item.
// Depends on msap_pkg.
interface msap_out_if;
    logic                         valid;
    logic                         ready;
    logic [msap_pkg::PINS_W-1:0]  pins;
    logic                         status;

    modport source (output valid, output pins, output status, input ready);
    modport sink   (input valid, input pins, input status, output ready);
endinterface

### hw/rtl/multichannel_servo_angle_pwm.sv
`timescale 1ns / 1ps
// Top level of the multichannel RC servo pulse generator.
// Depends on msap_pkg, msap_in_if, msap_out_if and msap_frame.
//
//  port   dir   handshake     payload
//  -----  ----  ------------  ---------------------------------------
//  req    in    valid/ready   cmd[0], channel[7:0], angle[7:0] signed
//  rsp    out   valid/ready   pins[7:0], status[0]
//  cfg    in    cfg_we        cfg_index[1:0], cfg_data[11:0]
//
// One item per cycle while the output is not stalled: each command is handled in the cycle
// it is taken and its result lands in the output register on that edge.
// req.ready drops only while a result sits in the output register and rsp.ready
// is low, so a stall holds everything with no item lost.
// Reset clears the frame to the start of base high, disables all channels and
// loads base_high_ticks = 50, gap_ticks = 1749. No clearing pass is needed.
module multichannel_servo_angle_pwm #(
    parameter int CHANNELS = 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [msap_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [msap_pkg::CFG_DATA_W-1:0]    cfg_data,
    msap_in_if.sink                            req,
    msap_out_if.source                         rsp
);
    import msap_pkg::*;

    localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [PINS_W-1:0] CH_MASK = PINS_W'((9'd1 << CHANNELS) - 9'd1);

    // Configuration registers
    logic [BASE_W-1:0] base_high_reg;
    logic [GAP_W-1:0]  gap_reg;

    // Channel state
    logic [CHANNELS-1:0] enable_mask_reg, enable_mask_next;
    logic [PWIDTH_W-1:0] pulse_width_reg [CHANNELS];
    logic [PWIDTH_W-1:0] pulse_width_next [CHANNELS];

    // Output register
    logic              rsp_valid_reg;
    logic [PINS_W-1:0] rsp_pins_reg, rsp_pins_next;
    logic              rsp_status_reg, rsp_status_next;

    logic              accept;
    logic              tick;
    frame_t            frame;
    logic [CHANNELS-1:0] width_hit;
    logic [CHANNELS-1:0] width_nz;
    logic              chan_ok;
    logic              angle_ok;
    logic [CH_IDX_W-1:0] ch_idx;
    logic [PWIDTH_W-1:0] new_width;

    // Ready whenever the output register is free or is being emptied.
    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;
    assign tick      = accept && (req.cmd == CMD_TICK);

    msap_frame u_frame (
        .clk             (clk),
        .rst_n           (rst_n),
        .tick            (tick),
        .base_high_ticks (base_high_reg),
        .gap_ticks       (gap_reg),
        .frame           (frame)
    );

    // Width phase: each channel stays high while the slot index is below its width.
    always_comb
    begin
        for (int n = 0; n < CHANNELS; n++)
        begin
            width_hit[n] = frame.count < COUNT_W'(pulse_width_reg[n]);
            width_nz[n]  = pulse_width_reg[n] != '0;
        end
    end

    assign chan_ok   = {1'b0, req.channel} < (CHAN_W+1)'(CHANNELS);
    assign angle_ok  = (req.angle <= ANGLE_MAX) && (req.angle >= ANGLE_MIN);
    assign ch_idx    = req.channel[CH_IDX_W-1:0];
    assign new_width = angle_width(req.angle);

    always_comb
    begin
        enable_mask_next = enable_mask_reg;
        pulse_width_next = pulse_width_reg;
        rsp_pins_next    = '0;
        rsp_status_next  = STATUS_OK;
        unique case (req.cmd)
            CMD_TICK:
            begin
                unique case (frame.phase)
                    PH_BASE:  rsp_pins_next = PINS_W'(enable_mask_reg);
                    PH_WIDTH: rsp_pins_next = PINS_W'(width_hit);
                    PH_GAP:   rsp_pins_next = '0;
                    default:  rsp_pins_next = '0;
                endcase
            end
            CMD_SET:
            begin
                if (!chan_ok)
                    rsp_status_next = STATUS_BAD_CHAN;
                else if (angle_ok)
                begin
                    enable_mask_next[ch_idx] = 1'b1;
                    pulse_width_next[ch_idx] = new_width;
                end
                else
                begin
                    // Out-of-range angle turns the channel off.
                    enable_mask_next[ch_idx] = 1'b0;
                    pulse_width_next[ch_idx] = '0;
                end
            end
            default:
            begin
                rsp_status_next = STATUS_OK;
            end
        endcase
    end

    // Config registers; unknown indexes are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_high_reg <= BASE_HIGH_RESET;
            gap_reg       <= GAP_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_BASE_HIGH)
                base_high_reg <= cfg_data[BASE_W-1:0];
            else if (cfg_index == REG_GAP)
                gap_reg <= cfg_data[GAP_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_mask_reg <= '0;
            for (int n = 0; n < CHANNELS; n++)
                pulse_width_reg[n] <= '0;
        end
        else if (accept)
        begin
            enable_mask_reg <= enable_mask_next;
            pulse_width_reg <= pulse_width_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (accept)
            rsp_valid_reg <= 1'b1;
        else if (rsp.ready)
            rsp_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_pins_reg   <= rsp_pins_next;
            rsp_status_reg <= rsp_status_next;
        end
    end

    assign rsp.valid  = rsp_valid_reg;
    assign rsp.pins   = rsp_pins_reg;
    assign rsp.status = rsp_status_reg;

`ifndef SYNTHESIS
    // An error result never drives a pin.
    a_status_no_pins: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && (rsp.status == STATUS_BAD_CHAN) |-> rsp.pins == '0)
        else $error("error result with pins driven");

    // Slot index stays inside the width phase.
    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        frame.phase == PH_WIDTH |-> frame.count < WIDTH_SLOTS)
        else $error("slot index past width phase");

    // A channel is enabled exactly when it holds a nonzero width.
    a_enable_width: assert property (@(posedge clk) disable iff (!rst_n)
        enable_mask_reg == width_nz)
        else $error("enable mask and widths disagree");

    // Pins of channels that do not exist stay low.
    a_unused_pins: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (rsp.pins & ~CH_MASK) == '0)
        else $error("unused channel pin driven");
`endif

endmodule

### hw/rtl/msap_frame.sv
`timescale 1ns / 1ps
// Frame sequencer: phase and tick count through base-high, width and gap phases.
// Depends on msap_pkg.
module msap_frame (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          tick,
    input  logic [msap_pkg::BASE_W-1:0]   base_high_ticks,
    input  logic [msap_pkg::GAP_W-1:0]    gap_ticks,
    output msap_pkg::frame_t              frame
);
    import msap_pkg::*;

    phase_t             phase_reg, phase_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [COUNT_W-1:0] len;
    logic               done;

    // A zero length ends the phase on the first tick, same as one.
    always_comb
    begin
        unique case (phase_reg)
            PH_BASE:  len = COUNT_W'(base_high_ticks);
            PH_WIDTH: len = WIDTH_SLOTS;
            PH_GAP:   len = COUNT_W'(gap_ticks);
            default:  len = '0;
        endcase
        done = ({1'b0, count_reg} + (COUNT_W+1)'(1)) >= {1'b0, len};
    end

    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        if (tick)
        begin
            unique case (phase_reg)
                PH_BASE:  phase_next = done ? PH_WIDTH : PH_BASE;
                PH_WIDTH: phase_next = done ? PH_GAP : PH_WIDTH;
                PH_GAP:   phase_next = done ? PH_BASE : PH_GAP;
                default:  phase_next = PH_BASE;
            endcase
            if (done || (phase_reg != PH_BASE && phase_reg != PH_WIDTH && phase_reg != PH_GAP))
                count_next = '0;
            else
                count_next = count_reg + COUNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_BASE;
            count_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
        end
    end

    assign frame.phase = phase_reg;
    assign frame.count = count_reg;

endmodule

### tb/servo_pulse_checker.sv
`timescale 1ns / 1ps
// Checker for the servo pulse generator: tracks frame and channel state, predicts each result.
// Depends on msap_pkg, msap_in_if and msap_out_if.
module servo_pulse_checker #(
    parameter int CHANNELS = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [msap_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [msap_pkg::CFG_DATA_W-1:0] cfg_data,
    msap_in_if                              req,
    msap_out_if                             rsp,
    output int                              mismatches,
    output int                              pending
);
    import msap_pkg::*;

    typedef struct packed {
        logic [PINS_W-1:0] pins;
        logic              status;
    } servo_result_t;

    phase_t               frame_phase;
    logic [COUNT_W-1:0]   slot_count;
    logic [PINS_W-1:0]    enabled;
    logic [PWIDTH_W-1:0]  width_of [8];
    logic [BASE_W-1:0]    base_len;
    logic [GAP_W-1:0]     gap_len;

    servo_result_t        pins_due [$];

    // A length of zero behaves as one tick.
    function automatic bit phase_ends(int unsigned len);
        return 32'(slot_count) + 32'd1 >= len;
    endfunction

    function automatic servo_result_t predict_pins(logic c, logic [CHAN_W-1:0] ch,
                                                   logic signed [ANGLE_W-1:0] ang);
        servo_result_t r;
        int            deg;
        r.pins   = '0;
        r.status = STATUS_OK;
        deg      = ang;
        if (c == CMD_TICK)
        begin
            case (frame_phase)
                PH_BASE:
                begin
                    r.pins = enabled;
                    if (phase_ends(base_len))
                    begin
                        frame_phase = PH_WIDTH;
                        slot_count  = '0;
                    end
                    else
                        slot_count = slot_count + 1'b1;
                end
                PH_WIDTH:
                begin
                    for (int n = 0; n < CHANNELS && n < 8; n++)
                        if (slot_count < width_of[n])
                            r.pins[n] = 1'b1;
                    if (phase_ends(32'(WIDTH_SLOTS)))
                    begin
                        frame_phase = PH_GAP;
                        slot_count  = '0;
                    end
                    else
                        slot_count = slot_count + 1'b1;
                end
                PH_GAP:
                begin
                    if (phase_ends(gap_len))
                    begin
                        frame_phase = PH_BASE;
                        slot_count  = '0;
                    end
                    else
                        slot_count = slot_count + 1'b1;
                end
                default:
                begin
                    frame_phase = PH_BASE;
                    slot_count  = '0;
                end
            endcase
        end
        else if (ch >= CHANNELS)
            r.status = STATUS_BAD_CHAN;
        else if (deg > int'(ANGLE_MAX) || deg < int'(ANGLE_MIN))
        begin
            enabled[ch[2:0]]  = 1'b0;
            width_of[ch[2:0]] = '0;
        end
        else
        begin
            enabled[ch[2:0]]  = 1'b1;
            width_of[ch[2:0]] = PWIDTH_W'((8 * deg + 900) / 9);
        end
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        mismatches++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        servo_result_t want;
        if (!rst_n)
        begin
            frame_phase = PH_BASE;
            slot_count  = '0;
            enabled     = '0;
            for (int n = 0; n < 8; n++)
                width_of[n] = '0;
            base_len    = BASE_HIGH_RESET;
            gap_len     = GAP_RESET;
            mismatches  = 0;
            pins_due.delete();
        end
        else
        begin
            // Compare before queuing this edge's item so a stray result cannot match it.
            if (rsp.valid && rsp.ready)
            begin
                if (pins_due.size() == 0)
                    report_mismatch($sformatf("result pins %02h status %0b with none due",
                                              rsp.pins, rsp.status));
                else
                begin
                    want = pins_due.pop_front();
                    if (rsp.pins !== want.pins)
                        report_mismatch($sformatf("pins got %02h want %02h",
                                                  rsp.pins, want.pins));
                    if (rsp.status !== want.status)
                        report_mismatch($sformatf("status got %0b want %0b",
                                                  rsp.status, want.status));
                end
            end
            if (req.valid && req.ready)
                pins_due.push_back(predict_pins(req.cmd, req.channel, req.angle));
            if (cfg_we)
            begin
                if (cfg_index == REG_BASE_HIGH)
                    base_len = cfg_data[BASE_W-1:0];
                else if (cfg_index == REG_GAP)
                    gap_len = cfg_data[GAP_W-1:0];
            end
        end
        pending = pins_due.size();
    end

endmodule

### tb/multichannel_servo_angle_pwm_test.sv
`timescale 1ns / 1ps
// Testbench top of the servo pulse generator: clock, reset, stimulus and the verdict.
// Depends on msap_pkg, msap_in_if, msap_out_if, servo_pulse_checker and the block.
module multichannel_servo_angle_pwm_test;
    import msap_pkg::*;

    // Index with no register behind it; writes there must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
    // Long receiver hold-off, enough to back the block up into its input.
    localparam int HOLD_OFF_CYCLES = 400;
    // Cap on a single sender gap so the run length stays bounded.
    localparam int MAX_SEND_GAP = 30;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_requests = 0;
    int holds_served  = 0;
    int hold_left     = 0;
    int mismatches;
    int pending;

    msap_in_if  req_ch ();
    msap_out_if rsp_ch ();

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    multichannel_servo_angle_pwm DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    servo_pulse_checker #(.CHANNELS(8)) pin_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .req        (req_ch),
        .rsp        (rsp_ch),
        .mismatches (mismatches),
        .pending    (pending)
    );

    // Result side. Random stalls at stall_pct; a hold-off request from the stimulus
    // turns into a long run of ready low, counted down here cycle by cycle.
    always @(posedge clk)
    begin
        if (hold_left == 0 && holds_served != hold_requests)
        begin
            holds_served++;
            hold_left = HOLD_OFF_CYCLES;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
        end
        else
            rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Safety net: a hung handshake ends the run as a failure.
    initial
    begin
        #20_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // Offer one item, after a random idle gap, and return at the edge it is taken.
    // Valid stays high into the next item when there is no gap.
    task automatic send_item(logic c, logic [CHAN_W-1:0] ch, logic signed [ANGLE_W-1:0] ang);
        int gap;
        gap = 0;
        while (gap < MAX_SEND_GAP && $urandom_range(0, 99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.cmd     <= c;
        req_ch.channel <= ch;
        req_ch.angle   <= ang;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
    endtask

    // Stop offering and wait for every outstanding result so nothing is still in flight.
    task automatic drain();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Rewrite both timing registers and poke the spare index. Only called with the
    // block idle. Upper data bits of the base write are junk that must be dropped.
    task automatic set_timing(logic [BASE_W-1:0] base, logic [GAP_W-1:0] gap);
        cfg_we    <= 1'b1;
        cfg_index <= REG_BASE_HIGH;
        cfg_data  <= CFG_DATA_W'(base) | (CFG_DATA_W'($urandom_range(0, 15)) << BASE_W);
        @(posedge clk);
        cfg_index <= REG_GAP;
        cfg_data  <= gap;
        @(posedge clk);
        cfg_index <= REG_SPARE;
        cfg_data  <= CFG_DATA_W'($urandom);
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Random traffic: mostly ticks so frames actually advance, sets mostly on real
    // channels with in-range angles, plus bad channels and disabling angles.
    // With_hold asks for one long receiver hold-off halfway through.
    task automatic run_random(int count, int idle_pct, int stall, bit with_hold);
        logic                      c;
        logic [CHAN_W-1:0]         ch;
        logic signed [ANGLE_W-1:0] ang;
        send_idle_pct = idle_pct;
        stall_pct     = stall;
        for (int i = 0; i < count; i++)
        begin
            if (with_hold && i == count / 2)
                hold_requests++;
            c   = ($urandom_range(0, 99) < 70) ? CMD_TICK : CMD_SET;
            ch  = ($urandom_range(0, 99) < 85) ? CHAN_W'($urandom_range(0, 7))
                                                : CHAN_W'($urandom_range(0, 255));
            ang = ($urandom_range(0, 99) < 80) ? ANGLE_W'($urandom_range(0, 180) - 90)
                                                : ANGLE_W'($urandom_range(0, 255));
            send_item(c, ch, ang);
        end
        drain();
    endtask

    initial
    begin
        rst_n          <= 1'b0;
        cfg_we         <= 1'b0;
        cfg_index      <= REG_BASE_HIGH;
        cfg_data       <= '0;
        req_ch.valid   <= 1'b0;
        req_ch.cmd     <= CMD_TICK;
        req_ch.channel <= '0;
        req_ch.angle   <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: angle limits, just-out-of-range and extreme angles, bad channels,
        // disabling an enabled channel, then ticks with noise in the unused fields.
        // Sets must give pins 0 and leave the frame where it is.
        send_item(CMD_SET,  8'd0,   -8'sd90);
        send_item(CMD_SET,  8'd1,    8'sd90);
        send_item(CMD_SET,  8'd2,    8'sd0);
        send_item(CMD_SET,  8'd3,   -8'sd91);
        send_item(CMD_SET,  8'd4,    8'sd91);
        send_item(CMD_SET,  8'd5,    8'sd127);
        send_item(CMD_SET,  8'd6,    8'h80);
        send_item(CMD_SET,  8'd7,    8'sd1);
        send_item(CMD_SET,  8'd8,    8'sd0);
        send_item(CMD_SET,  8'd255, -8'sd1);
        send_item(CMD_SET,  8'd128,  8'sd90);
        send_item(CMD_TICK, 8'd0,    8'sd0);
        send_item(CMD_SET,  8'd3,    8'sd45);
        send_item(CMD_SET,  8'd5,   -8'sd89);
        send_item(CMD_TICK, 8'd255, -8'sd1);
        send_item(CMD_SET,  8'd5,    8'h80);
        send_item(CMD_TICK, 8'd9,    8'sd127);
        send_item(CMD_TICK, 8'd0,    8'h80);
        send_item(CMD_SET,  8'd2,    8'sd127);
        send_item(CMD_TICK, 8'd0,    8'sd0);
        send_item(CMD_TICK, 8'd0,    8'sd0);
        send_item(CMD_SET,  8'd7,   -8'sd45);
        send_item(CMD_TICK, 8'd0,    8'sd0);
        drain();

        // Shortest frames, no idling on either side.
        set_timing(8'd1, 12'd1);
        run_random(300, 0, 0, 1'b0);

        // Short frames, sender idle about half the time.
        set_timing(8'd3, 12'd5);
        run_random(300, 52, 0, 1'b0);

        // Zero lengths act as one tick; receiver stalls, with a long hold-off that
        // fills the output register and pushes back on the command side.
        set_timing(8'd0, 12'd0);
        run_random(250, 0, 52, 1'b1);

        // Longest settings; the frame sits deep in base high when this ends.
        set_timing(8'd255, 12'd4095);
        run_random(150, 7, 7, 1'b0);

        // Lowered mid-phase: base high must end on the next tick.
        set_timing(8'd2, 12'd3);
        run_random(250, 52, 52, 1'b0);

        // Random mid-range timing, light idling, one more hold-off.
        set_timing(8'($urandom_range(1, 12)), 12'($urandom_range(1, 30)));
        run_random(250, 7, 7, 1'b1);

        if (mismatches == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

### filelist.f
hw/rtl/msap_pkg.sv
hw/rtl/msap_in_if.sv
hw/rtl/msap_out_if.sv
hw/rtl/msap_frame.sv
hw/rtl/multichannel_servo_angle_pwm.sv
tb/servo_pulse_checker.sv
tb/multichannel_servo_angle_pwm_test.sv
